/* rtl/core/ace_pkg.sv */
// Package: opcodes, status codes and shared structs of the accumulator execute block.
`timescale 1ns / 1ps
`default_nettype none

package ace_pkg;

    typedef enum logic [3:0] {
        OP_LDI     = 4'd0,
        OP_INC     = 4'd1,
        OP_DEC     = 4'd2,
        OP_JMP     = 4'd3,
        OP_STO     = 4'd4,
        OP_LOAD    = 4'd5,
        OP_ADD     = 4'd6,
        OP_SUB     = 4'd7,
        OP_READ    = 4'd8,
        OP_WRITE   = 4'd9,
        OP_JZERO   = 4'd10,
        OP_JGTZ    = 4'd11,
        OP_BSS     = 4'd12,
        OP_BRSA    = 4'd13,
        OP_HALT    = 4'd14,
        OP_UNKNOWN = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_ADDR    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4,
        ST_UNKNOWN = 3'd5,
        ST_STOPPED = 3'd6
    } t_status;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] acc;
        logic [31:0] pc;
        logic        wr_valid;
        logic [31:0] wr_data;
    } t_result;

    // Side effects of one executed item.
    typedef struct packed {
        logic dmem_we;
        logic push;
        logic pop;
        logic stop;
    } t_exec_ctl;

    localparam int unsigned TDATA_IN_W   = 64;
    localparam int unsigned TUSER_IN_W   = 4;
    localparam int unsigned TDATA_OUT_W  = 96;
    localparam int unsigned TUSER_OUT_W  = 4;

endpackage

`default_nettype wire

/* rtl/core/accumulator_cpu_execute.sv */
// Top level: accumulator machine execute block with data memory and return stack.
`timescale 1ns / 1ps
`default_nettype none

// Executes one decoded instruction per item and returns one result item for each.
// Throughput is one item per clock while the output is not stalled: an item reads
// the data memory and the return stack in the cycle it is accepted (both memories
// have a registered read) and executes once the output register is free or being
// emptied, while the next item is already being accepted. Its result item is then
// held in an output register until taken, which lets a new item enter while a
// result waits. A write to the entry that the following item reads is forwarded.
// After reset the data memory is cleared, one word per cycle, so no item is
// accepted until the sweep is done. Once HALT or an error is reported, every later
// item returns the already-stopped status until reset.
module accumulator_cpu_execute #(
    parameter int MEM_WORDS   = 16,
    parameter int STACK_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] operand, [63:32] read_value
    input  logic [ace_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,
    // [3:0] kind
    input  logic [ace_pkg::TUSER_IN_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] acc_value, [63:32] pc_value, [95:64] write_data
    output logic [ace_pkg::TDATA_OUT_W-1:0]   o_m_axis_tdata,
    // [2:0] status, [3] write_valid
    output logic [ace_pkg::TUSER_OUT_W-1:0]   o_m_axis_tuser
);
    import ace_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);

    // memories
    logic [31:0]   r_dmem [MEM_WORDS];
    logic [31:0]   r_stack [STACK_DEPTH];
    logic [31:0]   r_dmem_q;
    logic [31:0]   r_stack_q;

    // architectural state
    logic [31:0]   r_acc;
    logic [31:0]   r_pc;
    logic [PW-1:0] r_sp;
    logic [PW-1:0] n_sp;
    logic          r_stopped;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // execute stage
    logic          r_s1_valid;
    t_op           r_s1_kind;
    logic [31:0]   r_s1_operand;
    logic [31:0]   r_s1_read_value;
    logic [SW-1:0] r_s1_stk_addr;

    // last writes, for the item that read in the same cycle
    logic          r_dfwd_valid;
    logic [AW-1:0] r_dfwd_addr;
    logic [31:0]   r_dfwd_data;
    logic          r_sfwd_valid;
    logic [SW-1:0] r_sfwd_addr;
    logic [31:0]   r_sfwd_data;

    // output register
    logic          r_out_valid;
    t_result       r_out;

    logic          w_accept;
    logic          w_exec;
    logic [AW-1:0] w_rd_addr;
    logic [SW-1:0] w_stk_rd_addr;
    logic [PW-1:0] w_sp_m1;
    logic [31:0]   w_mem_data;
    logic [31:0]   w_stack_data;
    t_result       w_result;
    t_exec_ctl     w_ctl;

    assign w_exec   = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_clr_busy && (!r_s1_valid || w_exec);

    assign w_mem_data   = (r_dfwd_valid && (r_dfwd_addr == r_s1_operand[AW-1:0]))
                          ? r_dfwd_data : r_dmem_q;
    assign w_stack_data = (r_sfwd_valid && (r_sfwd_addr == r_s1_stk_addr))
                          ? r_sfwd_data : r_stack_q;

    ace_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .i_kind        (r_s1_kind),
        .i_operand     (r_s1_operand),
        .i_read_value  (r_s1_read_value),
        .i_acc         (r_acc),
        .i_pc          (r_pc),
        .i_stopped     (r_stopped),
        .i_mem_data    (w_mem_data),
        .i_stack_data  (w_stack_data),
        .i_stack_full  (r_sp == PW'(STACK_DEPTH)),
        .i_stack_empty (r_sp == '0),
        .o_result      (w_result),
        .o_ctl         (w_ctl)
    );

    // stack pointer as the accepting item will see it
    always_comb begin
        n_sp = r_sp;
        if (w_exec && w_ctl.push) begin
            n_sp = r_sp + PW'(1);
        end else if (w_exec && w_ctl.pop) begin
            n_sp = r_sp - PW'(1);
        end
    end

    assign w_sp_m1       = n_sp - PW'(1);
    assign w_stk_rd_addr = w_sp_m1[SW-1:0];
    assign w_rd_addr     = i_s_axis_tdata[AW-1:0];

    // data memory: clear sweep or STO write, read on accept
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_dmem[r_clr_addr] <= 32'd0;
        end else if (w_exec && w_ctl.dmem_we) begin
            r_dmem[r_s1_operand[AW-1:0]] <= r_acc;
        end
        if (w_accept) begin
            r_dmem_q <= r_dmem[w_rd_addr];
        end
    end

    // return stack: push writes at the pointer, read at the new top on accept
    always_ff @(posedge i_clk) begin
        if (w_exec && w_ctl.push) begin
            r_stack[r_sp[SW-1:0]] <= r_pc + 32'd1;
        end
        if (w_accept) begin
            r_stack_q <= r_stack[w_stk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= 32'd0;
            r_pc         <= 32'd0;
            r_sp         <= '0;
            r_stopped    <= 1'b0;
            r_dfwd_valid <= 1'b0;
            r_sfwd_valid <= 1'b0;
        end else if (w_exec) begin
            r_acc     <= w_result.acc;
            r_pc      <= w_result.pc;
            r_sp      <= n_sp;
            r_stopped <= r_stopped | w_ctl.stop;
            if (w_ctl.dmem_we) begin
                r_dfwd_valid <= 1'b1;
            end
            if (w_ctl.push) begin
                r_sfwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_ctl.dmem_we) begin
            r_dfwd_addr <= r_s1_operand[AW-1:0];
            r_dfwd_data <= r_acc;
        end
        if (w_exec && w_ctl.push) begin
            r_sfwd_addr <= r_sp[SW-1:0];
            r_sfwd_data <= r_pc + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_exec) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind       <= t_op'(i_s_axis_tuser[3:0]);
            r_s1_operand    <= i_s_axis_tdata[31:0];
            r_s1_read_value <= i_s_axis_tdata[63:32];
            r_s1_stk_addr   <= w_stk_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.wr_data, r_out.pc, r_out.acc};
    assign o_m_axis_tuser  = {r_out.wr_valid, r_out.status};

endmodule

`default_nettype wire

/* rtl/core/ace_exec.sv */
// Execute unit: decodes one item against the current machine state.
`timescale 1ns / 1ps
`default_nettype none

module ace_exec #(
    parameter int MEM_WORDS = 16
) (
    input  ace_pkg::t_op       i_kind,
    input  logic [31:0]        i_operand,
    input  logic [31:0]        i_read_value,
    input  logic [31:0]        i_acc,
    input  logic [31:0]        i_pc,
    input  logic               i_stopped,
    input  logic [31:0]        i_mem_data,
    input  logic [31:0]        i_stack_data,
    input  logic               i_stack_full,
    input  logic               i_stack_empty,
    output ace_pkg::t_result   o_result,
    output ace_pkg::t_exec_ctl o_ctl
);
    import ace_pkg::*;

    logic [31:0] w_next_pc;
    logic        w_addr_ok;

    assign w_next_pc = i_pc + 32'd1;
    // negative operands read as huge unsigned values and fail here too
    assign w_addr_ok = (i_operand < 32'(MEM_WORDS));

    always_comb begin
        o_result.status   = ST_OK;
        o_result.acc      = i_acc;
        o_result.pc       = i_pc;
        o_result.wr_valid = 1'b0;
        o_result.wr_data  = 32'd0;
        o_ctl             = '0;

        if (i_stopped) begin
            o_result.status = ST_STOPPED;
        end else begin
            case (i_kind)
                OP_LDI: begin
                    o_result.acc = i_operand;
                    o_result.pc  = w_next_pc;
                end
                OP_INC: begin
                    o_result.acc = i_acc + 32'd1;
                    o_result.pc  = w_next_pc;
                end
                OP_DEC: begin
                    o_result.acc = i_acc - 32'd1;
                    o_result.pc  = w_next_pc;
                end
                OP_JMP: begin
                    o_result.pc = i_operand;
                end
                OP_STO, OP_LOAD, OP_ADD, OP_SUB: begin
                    if (!w_addr_ok) begin
                        o_result.status = ST_ADDR;
                    end else begin
                        o_result.pc = w_next_pc;
                        case (i_kind)
                            OP_STO:  o_ctl.dmem_we = 1'b1;
                            OP_LOAD: o_result.acc = i_mem_data;
                            OP_ADD:  o_result.acc = i_acc + i_mem_data;
                            default: o_result.acc = i_acc - i_mem_data;
                        endcase
                    end
                end
                OP_READ: begin
                    o_result.acc = i_read_value;
                    o_result.pc  = w_next_pc;
                end
                OP_WRITE: begin
                    o_result.wr_valid = 1'b1;
                    o_result.wr_data  = i_acc;
                    o_result.pc       = w_next_pc;
                end
                OP_JZERO: begin
                    o_result.pc = (i_acc == 32'd0) ? i_operand : w_next_pc;
                end
                OP_JGTZ: begin
                    o_result.pc = ((i_acc != 32'd0) && !i_acc[31]) ? i_operand : w_next_pc;
                end
                OP_BSS: begin
                    if (i_stack_full) begin
                        o_result.status = ST_FULL;
                    end else begin
                        o_ctl.push  = 1'b1;
                        o_result.pc = i_operand;
                    end
                end
                OP_BRSA: begin
                    if (i_stack_empty) begin
                        o_result.status = ST_EMPTY;
                    end else begin
                        o_ctl.pop   = 1'b1;
                        o_result.pc = i_stack_data;
                    end
                end
                OP_HALT: begin
                    o_result.status = ST_HALT;
                end
                default: begin
                    o_result.status = ST_UNKNOWN;
                end
            endcase
            o_ctl.stop = (o_result.status != ST_OK);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ace_checker.sv */
// Port-level assertions for the accumulator execute block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ace_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [ace_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata,
    input logic [ace_pkg::TUSER_OUT_W-1:0] o_m_axis_tuser
);
    import ace_pkg::*;

    logic r_seen_stop;

    // set once a result other than ok has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_stop <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready &&
                     (o_m_axis_tuser[2:0] != ST_OK)) begin
            r_seen_stop <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result item changed while stalled");

    a_sticky_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && r_seen_stop |-> o_m_axis_tuser[2:0] == ST_STOPPED)
        else $error("item after stop not reported as stopped");

    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[3] |-> o_m_axis_tuser[2:0] == ST_OK)
        else $error("write flagged on a failed item");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[3] |-> o_m_axis_tdata[95:64] == 32'd0)
        else $error("write data not zero without write");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block not idle right after reset");

endmodule

bind accumulator_cpu_execute ace_checker u_ace_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
